// ===== src/pfur_pkg.sv =====
// Shared types, register indexes and reset values for the pack readiness block.
package pfur_pkg;

   localparam int SendersDefault   = 8;
   localparam int CellsDefault     = 16;

   localparam int SenderWidth      = 3;
   localparam int MvWidth          = 16;
   localparam int SocWidth         = 10;
   localparam int TempWidth        = 12;
   localparam int ReasonWidth      = 2;

   localparam int ReqDataWidth     = 80;
   localparam int RspDataWidth     = 8;
   localparam int CsrIndexWidth    = 3;
   localparam int CsrDataWidth     = 16;

   localparam logic [SocWidth-1:0]  MinSocReset    = 10'd300;
   localparam logic [MvWidth-1:0]   CellMinReset   = 16'd2500;
   localparam logic [MvWidth-1:0]   CellMaxReset   = 16'd4250;
   localparam logic [TempWidth-1:0] PackLimitReset = 12'd600;
   localparam logic [TempWidth-1:0] ChipLimitReset = 12'd750;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_SOC    = 3'd0,
      CSR_CELL_MIN   = 3'd1,
      CSR_CELL_MAX   = 3'd2,
      CSR_PACK_LIMIT = 3'd3,
      CSR_CHIP_LIMIT = 3'd4,
      CSR_BYPASS     = 3'd5
   } csr_index_type;

   typedef enum logic [ReasonWidth-1:0] {
      REASON_SAFE    = 2'd0,
      REASON_NO_DATA = 2'd1,
      REASON_LOW_SOC = 2'd2,
      REASON_FAULT   = 2'd3
   } reason_type;

   typedef enum logic {
      ST_IDLE   = 1'b0,
      ST_UPDATE = 1'b1
   } state_type;

   // first field in the highest bits
   typedef struct packed {
      logic [TempWidth-1:0]   monitor_temp;
      logic [TempWidth-1:0]   temp_three;
      logic [TempWidth-1:0]   temp_two;
      logic [TempWidth-1:0]   temp_one;
      logic [SocWidth-1:0]    soc_tenths;
      logic [MvWidth-1:0]     cell_mv;
      logic [SenderWidth-1:0] sender;
   } item_type;

   localparam int ItemWidth = $bits(item_type);

   typedef struct packed {
      logic [SenderWidth-1:0] failing_sender;
      reason_type             reason_code;
      logic                   fleet_safe;
      logic                   message_fault;
   } result_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic out_stall;
   } status_type;

endpackage

// ===== src/pack_fault_and_update_readiness.sv =====
// Top level of the battery fleet readiness checker.
//
// req_*: one beat per cell voltage of the named sender; tlast marks the
//   final cell of a message, whose beat also carries SoC and temperatures
//   and commits the sender's SoC, fault and data-seen entry.
// rsp_*: one beat per request beat: the fault committed by that beat and the
//   fleet verdict (safe, or the first failing sender with a reason code).
// csr_*: register writes by index, always ready; write only while idle.
// Flow: a request beat is captured into the item register in the capture
//   (idle) state of the controller and committed to the result register in
//   its commit (update) state; no new beat is taken until it is back in idle.
//   The fleet verdict is a single priority encode over the sender table.
// Reset: registers take their defaults, no sender has data yet, no result
//   is pending; the block takes a beat in the first cycle after reset.
// Stall: a result waits in the output register; one more request is taken
//   meanwhile and held until that register frees.
module pack_fault_and_update_readiness #(
   parameter int SENDERS           = pfur_pkg::SendersDefault,
   parameter int CELLS_PER_MESSAGE = pfur_pkg::CellsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // sender, cell_mv, soc_tenths, temp_one, temp_two, temp_three, monitor_temp
   input  logic [pfur_pkg::ReqDataWidth-1:0]  req_tdata,
   input  logic                               req_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // message_fault, fleet_safe, reason_code, failing_sender
   output logic [pfur_pkg::RspDataWidth-1:0]  rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pfur_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [pfur_pkg::CsrDataWidth-1:0]  csr_data
);
   import pfur_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type rsp_result;

   assign csr_ready = 1'b1;

   pfur_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pfur_dp #(
      .SENDERS           (SENDERS),
      .CELLS_PER_MESSAGE (CELLS_PER_MESSAGE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_item   (req_tdata[ItemWidth-1:0]),
      .req_last   (req_tlast),
      .csr_we     (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {{(RspDataWidth - $bits(result_type)){1'b0}}, rsp_result};

`ifndef NO_ASSERTIONS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second beat taken before commit");

   a_safe_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result.fleet_safe == (rsp_result.reason_code == REASON_SAFE)))
      else $error("verdict and reason disagree");

   a_safe_sender: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.fleet_safe) |-> (rsp_result.failing_sender == '0))
      else $error("safe verdict names a sender");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_tvalid && !rsp_tready))
      else $error("commit overwrote a waiting result");
`endif

endmodule

// ===== src/pfur_ctrl.sv =====
// Controller: accepts one beat, then commits it once the result register is free.
module pfur_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  pfur_pkg::status_type status,
   output pfur_pkg::cmd_type    cmd
);
   import pfur_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!status.out_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_UPDATE: begin
            cmd.commit = !status.out_stall;
         end
         default: ;
      endcase
   end

endmodule

// ===== src/pfur_dp.sv =====
// Datapath: config registers, sender table, cell checks, verdict encode, result register.
module pfur_dp #(
   parameter int SENDERS           = pfur_pkg::SendersDefault,
   parameter int CELLS_PER_MESSAGE = pfur_pkg::CellsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pfur_pkg::cmd_type                   cmd,
   output pfur_pkg::status_type                status,
   input  logic [pfur_pkg::ItemWidth-1:0]      req_item,
   input  logic                                req_last,
   input  logic                                csr_we,
   input  logic [pfur_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pfur_pkg::CsrDataWidth-1:0]   csr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output pfur_pkg::result_type                rsp_result
);
   import pfur_pkg::*;

   localparam int CntWidth = $clog2(CELLS_PER_MESSAGE + 1);

   logic [SocWidth-1:0]  min_soc_ff;
   logic [MvWidth-1:0]   cell_min_ff;
   logic [MvWidth-1:0]   cell_max_ff;
   logic [TempWidth-1:0] pack_limit_ff;
   logic [TempWidth-1:0] chip_limit_ff;
   logic                 bypass_ff;

   item_type             item_ff;
   logic                 last_ff;

   logic [SocWidth-1:0]  soc_ff   [SENDERS];
   logic [SENDERS-1:0]   fault_ff;
   logic [SENDERS-1:0]   seen_ff;
   logic                 pending_ff;
   logic                 pending_in;
   logic [CntWidth-1:0]  count_ff;
   logic [CntWidth-1:0]  count_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   result_type           rsp_ff;
   result_type           rsp_in;

   logic                 in_range;
   logic                 cell_check;
   logic                 cell_bad;
   logic                 pend_now;
   logic                 temp_bad;
   logic                 msg_fault;
   logic                 write_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_soc_ff    <= MinSocReset;
         cell_min_ff   <= CellMinReset;
         cell_max_ff   <= CellMaxReset;
         pack_limit_ff <= PackLimitReset;
         chip_limit_ff <= ChipLimitReset;
         bypass_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_SOC:    min_soc_ff    <= csr_data[SocWidth-1:0];
            CSR_CELL_MIN:   cell_min_ff   <= csr_data;
            CSR_CELL_MAX:   cell_max_ff   <= csr_data;
            CSR_PACK_LIMIT: pack_limit_ff <= csr_data[TempWidth-1:0];
            CSR_CHIP_LIMIT: chip_limit_ff <= csr_data[TempWidth-1:0];
            CSR_BYPASS:     bypass_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= item_type'(req_item);
         last_ff <= req_last;
      end
   end

   assign in_range   = int'(item_ff.sender) < SENDERS;
   assign cell_check = count_ff < CntWidth'(CELLS_PER_MESSAGE);
   assign cell_bad   = (item_ff.cell_mv != '0)
                       && ((item_ff.cell_mv < cell_min_ff) || (item_ff.cell_mv > cell_max_ff));
   assign pend_now   = pending_ff || (in_range && cell_check && cell_bad);
   assign temp_bad   = ($signed(item_ff.temp_one)     > $signed(pack_limit_ff))
                    || ($signed(item_ff.temp_two)     > $signed(pack_limit_ff))
                    || ($signed(item_ff.temp_three)   > $signed(pack_limit_ff))
                    || ($signed(item_ff.monitor_temp) > $signed(chip_limit_ff));
   assign write_entry = in_range && last_ff;
   assign msg_fault   = write_entry && (pend_now || temp_bad);

   always_comb begin
      pending_in = pending_ff;
      count_in   = count_ff;
      if (cmd.commit && in_range) begin
         if (last_ff) begin
            pending_in = 1'b0;
            count_in   = '0;
         end else begin
            pending_in = pend_now;
            if (cell_check) begin
               count_in = count_ff + CntWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         count_ff   <= '0;
         fault_ff   <= '0;
         seen_ff    <= '0;
         for (int i = 0; i < SENDERS; i++) begin
            soc_ff[i] <= '0;
         end
      end else begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
         for (int i = 0; i < SENDERS; i++) begin
            if (cmd.commit && write_entry && (int'(item_ff.sender) == i)) begin
               soc_ff[i]   <= item_ff.soc_tenths;
               fault_ff[i] <= msg_fault;
               seen_ff[i]  <= 1'b1;
            end
         end
      end
   end

   // verdict sees the entry written by this beat
   always_comb begin
      logic                found;
      logic                hit;
      logic                seen_v;
      logic                fault_v;
      logic [SocWidth-1:0] soc_v;
      found  = 1'b0;
      rsp_in = '{failing_sender: '0, reason_code: REASON_SAFE,
                 fleet_safe: 1'b1, message_fault: msg_fault};
      for (int i = 0; i < SENDERS; i++) begin
         hit     = write_entry && (int'(item_ff.sender) == i);
         seen_v  = hit ? 1'b1 : seen_ff[i];
         fault_v = hit ? msg_fault : fault_ff[i];
         soc_v   = hit ? item_ff.soc_tenths : soc_ff[i];
         if (!found && !bypass_ff) begin
            if (!seen_v) begin
               found                 = 1'b1;
               rsp_in.reason_code    = REASON_NO_DATA;
            end else if (soc_v < min_soc_ff) begin
               found                 = 1'b1;
               rsp_in.reason_code    = REASON_LOW_SOC;
            end else if (fault_v) begin
               found                 = 1'b1;
               rsp_in.reason_code    = REASON_FAULT;
            end
            if (found) begin
               rsp_in.fleet_safe     = 1'b0;
               rsp_in.failing_sender = SenderWidth'(i);
            end
         end
      end
   end

   assign status.out_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_valid_in     = cmd.commit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule
